// ===== hw/rtl/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/pidff_pkg.sv =====
`timescale 1ns / 1ps

package pidff_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned CfgW = 64;
    localparam int unsigned IdxW = 3;

    localparam logic [IdxW-1:0] REG_GAIN_P = 3'd0;
    localparam logic [IdxW-1:0] REG_GAIN_I = 3'd1;
    localparam logic [IdxW-1:0] REG_GAIN_D = 3'd2;
    localparam logic [IdxW-1:0] REG_GAIN_F = 3'd3;
    localparam logic [IdxW-1:0] REG_LIMITS = 3'd4;
    localparam logic [IdxW-1:0] REG_BANDS = 3'd5;
    localparam logic [IdxW-1:0] REG_SPEED = 3'd6;
    localparam logic [IdxW-1:0] REG_DFIRST = 3'd7;

    localparam logic signed [DataW-1:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [DataW-1:0] ZERO_Q16 = 32'sh0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERR,
        ST_DZ,
        ST_SPEED,
        ST_DIV,
        ST_DIVDONE,
        ST_MUL_P,
        ST_P,
        ST_MUL_IE,
        ST_IE,
        ST_MUL_IR,
        ST_IR,
        ST_INTEG,
        ST_MUL_D,
        ST_D,
        ST_MUL_F,
        ST_F,
        ST_SUM,
        ST_OUT
    } state_t;

    // request to the shared multiplier
    typedef struct packed {
        logic start;
        logic signed [DataW-1:0] a;
        logic signed [DataW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic done;
        logic signed [DataW-1:0] q;
    } mul_rsp_t;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [DataW+3:0] x);
        logic signed [DataW+3:0] hi;
        logic signed [DataW+3:0] lo;
        hi = {{4{1'b0}}, 1'b0, {(DataW-1){1'b1}}};
        lo = {{4{1'b1}}, 1'b1, {(DataW-1){1'b0}}};
        if (x > hi)
        begin
            return hi[DataW-1:0];
        end
        else if (x < lo)
        begin
            return lo[DataW-1:0];
        end
        return x[DataW-1:0];
    endfunction

endpackage

// ===== hw/rtl/pidff_if.sv =====
`timescale 1ns / 1ps

interface pidff_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] target;
    logic signed [31:0] measured;
    modport source (output valid, output target, output measured, input ready);
    modport sink (input valid, input target, input measured, output ready);
endinterface

interface pidff_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] drive;
    modport source (output valid, output drive, input ready);
    modport sink (input valid, input drive, output ready);
endinterface

// ===== hw/rtl/pidff_mul.sv =====
`timescale 1ns / 1ps

module pidff_mul
    import pidff_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;
    logic               done_reg;
    logic signed [47:0] shifted;

    assign prod_next = 64'(req.a) * 64'(req.b);
    // arithmetic shift is a floor
    assign shifted = 48'(prod_reg >>> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req.start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (shifted > 48'sh0000_7FFF_FFFF)
        begin
            rsp.q = 32'sh7FFF_FFFF;
        end
        else if (shifted < -48'sh0000_8000_0000)
        begin
            rsp.q = 32'sh8000_0000;
        end
        else
        begin
            rsp.q = shifted[31:0];
        end
    end

endmodule

// ===== hw/rtl/pidff_div.sv =====
`timescale 1ns / 1ps

module pidff_div
    import pidff_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] num,
    input  logic [32:0] den,
    output logic        busy,
    output logic [16:0] quo
);

    // restoring division, one quotient bit per cycle; quotient fits in 17 bits
    logic [47:0] rem_reg;
    logic [47:0] rem_next;
    logic [47:0] q_reg;
    logic [47:0] q_next;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic [32:0] den_reg;
    logic [48:0] trial;

    always_comb
    begin
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        trial = {rem_reg, q_reg[47]} - {16'd0, den_reg};
        if (start)
        begin
            rem_next = '0;
            q_next = num;
            cnt_next = 6'd48;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (!trial[48])
            begin
                rem_next = trial[47:0];
                q_next = {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[46:0], q_reg[47]};
                q_next = {q_reg[46:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign busy = (cnt_reg != 6'd0);
    assign quo = q_reg[16:0];

endmodule

// ===== hw/rtl/pid_deadzone_feedforward_unit.sv =====
`timescale 1ns / 1ps

// PID controller tick engine: dead zone, variable-speed integral with separation,
// optional derivative-first and target feedforward, all Q16.16 saturating. One
// beat in gives one drive beat out. A tick steps through the states in order, and when
// the error falls between the speed thresholds it also waits on the 48-step
// bit-serial divider. The five products go one after another through a single
// 32x32 multiplier. The block takes no new beat until the drive beat has been taken.
module pid_deadzone_feedforward_unit
    import pidff_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IdxW-1:0]     cfg_index,
    input  logic [CfgW-1:0]     cfg_data,
    pidff_in_if.sink            in_ch,
    pidff_out_if.source         out_ch
);

    logic signed [31:0] gp_reg, gi_reg, gd_reg, gf_reg;
    logic [63:0] lim_reg, band_reg, spd_reg;
    logic dfirst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gp_reg <= '0;
            gi_reg <= '0;
            gd_reg <= '0;
            gf_reg <= '0;
            lim_reg <= '0;
            band_reg <= '0;
            spd_reg <= '0;
            dfirst_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_P: gp_reg <= cfg_data[31:0];
                REG_GAIN_I: gi_reg <= cfg_data[31:0];
                REG_GAIN_D: gd_reg <= cfg_data[31:0];
                REG_GAIN_F: gf_reg <= cfg_data[31:0];
                REG_LIMITS: lim_reg <= cfg_data;
                REG_BANDS: band_reg <= cfg_data;
                REG_SPEED: spd_reg <= cfg_data;
                REG_DFIRST: dfirst_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic signed [31:0] tgt_reg, tgt_next, meas_reg, meas_next;
    logic signed [31:0] err_reg, err_next;
    logic [32:0] abs_reg, abs_next;
    logic signed [31:0] ratio_reg, ratio_next;
    logic signed [31:0] p_reg, p_next, t_reg, t_next, i_reg, i_next;
    logic signed [31:0] d_reg, d_next, f_reg, f_next;
    logic signed [31:0] acc_reg, acc_next, lerr_reg, lerr_next;
    logic signed [31:0] ldrv_reg, ldrv_next, ltgt_reg, ltgt_next;
    logic signed [31:0] drv_reg, drv_next;

    mul_req_t mreq;
    mul_rsp_t mrsp;
    logic div_start, div_busy;
    logic [47:0] div_num;
    logic [32:0] div_den;
    logic [16:0] div_q;

    pidff_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
    pidff_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
                     .den(div_den), .busy(div_busy), .quo(div_q));

    logic [32:0] dz, sep, tha, thb, ilim, olim;
    logic signed [33:0] acc_cl;
    logic signed [35:0] sum;

    assign ilim = {1'b0, lim_reg[31:0]};
    assign olim = {1'b0, lim_reg[63:32]};
    assign dz = {1'b0, band_reg[31:0]};
    assign sep = {1'b0, band_reg[63:32]};
    assign tha = {1'b0, spd_reg[31:0]};
    assign thb = {1'b0, spd_reg[63:32]};
    assign div_num = {15'd0, thb - abs_reg} << 16;
    assign div_den = thb - tha;

    always_comb
    begin
        state_next = state_reg;
        tgt_next = tgt_reg;
        meas_next = meas_reg;
        err_next = err_reg;
        abs_next = abs_reg;
        ratio_next = ratio_reg;
        p_next = p_reg;
        t_next = t_reg;
        i_next = i_reg;
        d_next = d_reg;
        f_next = f_reg;
        acc_next = acc_reg;
        lerr_next = lerr_reg;
        ldrv_next = ldrv_reg;
        ltgt_next = ltgt_reg;
        drv_next = drv_reg;
        mreq = '0;
        div_start = 1'b0;
        acc_cl = 34'(acc_reg);
        sum = 36'(p_reg) + 36'(i_reg) + 36'(d_reg) + 36'(f_reg);
        in_ch.ready = (state_reg == ST_IDLE);
        out_ch.valid = (state_reg == ST_OUT);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    tgt_next = in_ch.target;
                    meas_next = in_ch.measured;
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                err_next = sat32(36'(tgt_reg) - 36'(meas_reg));
                state_next = ST_DZ;
            end
            ST_DZ:
            begin
                abs_next = err_reg[31] ? 33'd0 - 33'(err_reg) : 33'(err_reg);
                if (abs_next < dz)
                begin
                    tgt_next = meas_reg;
                    err_next = '0;
                    abs_next = '0;
                end
                else if (abs_next > dz)
                begin
                    err_next = err_reg[31] ? 32'(33'(err_reg) + dz) : 32'(33'(err_reg) - dz);
                end
                state_next = ST_SPEED;
            end
            ST_SPEED:
            begin
                if ((tha == '0 && thb == '0) || abs_reg <= tha)
                begin
                    ratio_next = ONE_Q16;
                    state_next = ST_MUL_P;
                end
                else if (abs_reg < thb)
                begin
                    div_start = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    ratio_next = ZERO_Q16;
                    state_next = ST_MUL_P;
                end
            end
            ST_DIV:
            begin
                state_next = ST_DIVDONE;
            end
            ST_DIVDONE:
            begin
                if (!div_busy)
                begin
                    ratio_next = 32'(div_q);
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P:
            begin
                mreq = '{start: 1'b1, a: gp_reg, b: err_reg};
                state_next = ST_P;
            end
            ST_P:
            begin
                p_next = mrsp.q;
                state_next = ST_MUL_IE;
            end
            ST_MUL_IE:
            begin
                mreq = '{start: 1'b1, a: gi_reg, b: err_reg};
                state_next = ST_IE;
            end
            ST_IE:
            begin
                t_next = mrsp.q;
                state_next = ST_MUL_IR;
            end
            ST_MUL_IR:
            begin
                mreq = '{start: 1'b1, a: t_reg, b: ratio_reg};
                state_next = ST_IR;
            end
            ST_IR:
            begin
                t_next = mrsp.q;
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                if (ilim != '0)
                begin
                    if (34'(acc_reg) > $signed({1'b0, ilim}))
                    begin
                        acc_cl = $signed({1'b0, ilim});
                    end
                    else if (34'(acc_reg) < -$signed({1'b0, ilim}))
                    begin
                        acc_cl = -$signed({1'b0, ilim});
                    end
                end
                if (sep == '0 || abs_reg < sep)
                begin
                    acc_next = sat32(36'(acc_cl) + 36'(t_reg));
                end
                else
                begin
                    acc_next = '0;
                end
                i_next = acc_next;
                if (dfirst_reg)
                begin
                    t_next = sat32(sat32(36'(p_reg) + 36'(acc_next)) - 36'(ldrv_reg));
                end
                else
                begin
                    t_next = sat32(36'(err_reg) - 36'(lerr_reg));
                end
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                mreq = '{start: 1'b1, a: gd_reg, b: t_reg};
                state_next = ST_D;
            end
            ST_D:
            begin
                d_next = mrsp.q;
                t_next = sat32(36'(tgt_reg) - 36'(ltgt_reg));
                state_next = ST_MUL_F;
            end
            ST_MUL_F:
            begin
                mreq = '{start: 1'b1, a: t_reg, b: gf_reg};
                state_next = ST_F;
            end
            ST_F:
            begin
                f_next = mrsp.q;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (olim != '0)
                begin
                    if (sum > 36'($signed({1'b0, olim})))
                    begin
                        sum = 36'($signed({1'b0, olim}));
                    end
                    else if (sum < -36'($signed({1'b0, olim})))
                    begin
                        sum = -36'($signed({1'b0, olim}));
                    end
                end
                drv_next = sat32(sum);
                ldrv_next = drv_next;
                lerr_next = err_reg;
                ltgt_next = tgt_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_ch.drive = drv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg <= '0;
            lerr_reg <= '0;
            ldrv_reg <= '0;
            ltgt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg <= acc_next;
            lerr_reg <= lerr_next;
            ldrv_reg <= ldrv_next;
            ltgt_reg <= ltgt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg <= tgt_next;
        meas_reg <= meas_next;
        err_reg <= err_next;
        abs_reg <= abs_next;
        ratio_reg <= ratio_next;
        p_reg <= p_next;
        t_reg <= t_next;
        i_reg <= i_next;
        d_reg <= d_next;
        f_reg <= f_next;
        drv_reg <= drv_next;
    end

endmodule

// ===== hw/rtl/pidff_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pidff_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] drive
);

    `ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_NEXT(a_drive_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(drive))
    `ASSERT_NEXT(a_free_after_out, clk, rst_n, out_valid && out_ready, in_ready && !out_valid)

endmodule

bind pid_deadzone_feedforward_unit pidff_checker u_pidff_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .drive(out_ch.drive)
);

// ===== verif/pidff_tb_if.sv =====
`timescale 1ns / 1ps

// channel interfaces come from the rtl; this file holds the stimulus beat type
package pidff_tb_pkg;

    typedef struct packed {
        logic signed [31:0] target;
        logic signed [31:0] measured;
    } tick_t;

endpackage

// ===== verif/pid_deadzone_feedforward_unit_tb.sv =====
`timescale 1ns / 1ps

module pid_deadzone_feedforward_unit_tb;
    import pidff_pkg::*;
    import pidff_tb_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IdxW-1:0] cfg_index;
    logic [CfgW-1:0] cfg_data;

    pidff_in_if in_ch ();
    pidff_out_if out_ch ();

    pid_deadzone_feedforward_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    localparam int WatchdogLimit = 20000;

    // controller copy
    logic signed [31:0] kp, ki, kd, kf;
    logic [63:0] lim_reg, band_reg, speed_reg;
    logic dfirst;
    logic signed [31:0] integ, prev_err, prev_drive, prev_target;

    tick_t tick_queue[$];
    logic signed [31:0] drive_queue[$];
    int failures;
    int watchdog;
    bit rand_idle;
    bit hold_off;
    int hold_cycles;
    int in_gap;
    int out_gap;
    int pending;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic signed [31:0] sat(input logic signed [65:0] x);
        if (x > 66'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        if (x < -66'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [65:0] prod;
        prod = a * b;
        return sat(prod >>> 16);
    endfunction

    function automatic logic signed [65:0] clamp_mag(input logic signed [65:0] x,
                                                     input logic signed [65:0] m);
        if (x > m)
        begin
            return m;
        end
        if (x < -m)
        begin
            return -m;
        end
        return x;
    endfunction

    function automatic logic signed [31:0] control_tick(input tick_t t);
        logic signed [31:0] tgt, err, p, iterm, d, f, pi, inc, drv;
        logic signed [65:0] abs_err, dz, sep, a, b, ratio, acc, sum, il, ol;
        tgt = t.target;
        il = $signed({34'd0, lim_reg[31:0]});
        ol = $signed({34'd0, lim_reg[63:32]});
        dz = $signed({34'd0, band_reg[31:0]});
        sep = $signed({34'd0, band_reg[63:32]});
        a = $signed({34'd0, speed_reg[31:0]});
        b = $signed({34'd0, speed_reg[63:32]});
        err = sat(66'(tgt) - 66'(t.measured));
        abs_err = err < 0 ? -66'(err) : 66'(err);
        if (abs_err < dz)
        begin
            tgt = t.measured;
            err = 0;
            abs_err = 0;
        end
        else if (err > 0 && abs_err > dz)
        begin
            err = 32'(66'(err) - dz);
        end
        else if (err < 0 && abs_err > dz)
        begin
            err = 32'(66'(err) + dz);
        end
        p = qmul(kp, err);
        if ((a == 0 && b == 0) || abs_err <= a)
        begin
            ratio = 66'sd65536;
        end
        else if (abs_err < b)
        begin
            ratio = ((b - abs_err) <<< 16) / (b - a);
        end
        else
        begin
            ratio = 0;
        end
        acc = 66'(integ);
        if (il != 0)
        begin
            acc = clamp_mag(acc, il);
        end
        if (sep == 0 || abs_err < sep)
        begin
            inc = qmul(qmul(ki, err), ratio[31:0]);
            integ = sat(acc + 66'(inc));
            iterm = integ;
        end
        else
        begin
            integ = 0;
            iterm = 0;
        end
        if (!dfirst)
        begin
            d = qmul(kd, sat(66'(err) - 66'(prev_err)));
        end
        else
        begin
            pi = sat(66'(p) + 66'(iterm));
            d = qmul(kd, sat(66'(pi) - 66'(prev_drive)));
        end
        f = qmul(sat(66'(tgt) - 66'(prev_target)), kf);
        sum = 66'(p) + 66'(iterm) + 66'(d) + 66'(f);
        if (ol != 0)
        begin
            sum = clamp_mag(sum, ol);
        end
        drv = sat(sum);
        prev_target = tgt;
        prev_drive = drv;
        prev_err = err;
        return drv;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.target <= '0;
            in_ch.measured <= '0;
            in_gap <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                drive_queue.push_back(control_tick({in_ch.target, in_ch.measured}));
            end
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                if (in_ch.valid && in_ch.ready)
                begin
                    in_ch.valid <= 1'b0;
                end
            end
            else if (!in_ch.valid || in_ch.ready)
            begin
                if (rand_idle && $urandom_range(0, 5) == 0)
                begin
                    in_ch.valid <= 1'b0;
                    in_gap <= $urandom_range(1, 9);
                end
                else if (tick_queue.size() > 0)
                begin
                    tick_t t;
                    t = tick_queue.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.target <= t.target;
                    in_ch.measured <= t.measured;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap <= 0;
            hold_cycles <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (drive_queue.size() == 0)
                begin
                    $display("%0t: unexpected drive beat, actual %0d", $time, out_ch.drive);
                    failures++;
                end
                else
                begin
                    logic signed [31:0] want;
                    want = drive_queue.pop_front();
                    if (want !== out_ch.drive)
                    begin
                        $display("%0t: drive mismatch, expected %0d, actual %0d",
                                 $time, want, out_ch.drive);
                        failures++;
                    end
                end
            end
            if (hold_off)
            begin
                out_ch.ready <= 1'b0;
                hold_cycles <= hold_cycles + 1;
            end
            else if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else if (rand_idle && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                out_gap <= $urandom_range(1, 9);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (tick_queue.size() == 0 && drive_queue.size() == 0))
        begin
            watchdog <= 0;
        end
        else
        begin
            watchdog <= watchdog + 1;
        end
        if (watchdog >= WatchdogLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (tick_queue.size() > 0 || in_ch.valid || drive_queue.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GAIN_P: kp = val[31:0];
            REG_GAIN_I: ki = val[31:0];
            REG_GAIN_D: kd = val[31:0];
            REG_GAIN_F: kf = val[31:0];
            REG_LIMITS: lim_reg = val;
            REG_BANDS: band_reg = val;
            REG_SPEED: speed_reg = val;
            default: dfirst = val[0];
        endcase
    endtask

    function automatic logic signed [31:0] rand_value(input int scale);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 3) == 0 ? 32'sh80000000 : 32'sh7fffffff;
            default: return $signed($urandom_range(0, 2 * scale)) - scale;
        endcase
    endfunction

    function automatic logic [31:0] rand_band(input int scale);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return $urandom;
            default: return $urandom_range(1, scale);
        endcase
    endfunction

    task automatic random_setting(input bit extreme);
        logic [31:0] sa, sb;
        if (extreme)
        begin
            write_reg(REG_GAIN_P, {32'h0, 32'h7fffffff});
            write_reg(REG_GAIN_I, {32'h0, 32'h80000000});
            write_reg(REG_GAIN_D, {32'h0, 32'h7fffffff});
            write_reg(REG_GAIN_F, {32'h0, 32'h80000000});
            write_reg(REG_LIMITS, 64'hffffffff_ffffffff);
            write_reg(REG_BANDS, 64'hffffffff_ffffffff);
            write_reg(REG_SPEED, 64'hffffffff_fffffffe);
            write_reg(REG_DFIRST, 64'h1);
            return;
        end
        write_reg(REG_GAIN_P, {32'h0, rand_value(1 << 18)});
        write_reg(REG_GAIN_I, {32'h0, rand_value(1 << 16)});
        write_reg(REG_GAIN_D, {32'h0, rand_value(1 << 16)});
        write_reg(REG_GAIN_F, {32'h0, rand_value(1 << 16)});
        write_reg(REG_LIMITS, {rand_band(1 << 24), rand_band(1 << 22)});
        write_reg(REG_BANDS, {rand_band(1 << 22), rand_band(1 << 18)});
        sa = $urandom_range(0, 1 << 19);
        sb = sa + $urandom_range(1, 1 << 20);
        case ($urandom_range(0, 3))
            0: write_reg(REG_SPEED, 64'h0);
            1: write_reg(REG_SPEED, {32'h0, sa});
            default: write_reg(REG_SPEED, {sb, sa});
        endcase
        write_reg(REG_DFIRST, {63'h0, 1'($urandom_range(0, 1))});
    endtask

    task automatic push_tick(input logic signed [31:0] t, input logic signed [31:0] m);
        tick_queue.push_back({t, m});
    endtask

    initial
    begin
        failures = 0;
        rand_idle = 1'b0;
        hold_off = 1'b0;
        kp = 0;
        ki = 0;
        kd = 0;
        kf = 0;
        lim_reg = 0;
        band_reg = 0;
        speed_reg = 0;
        dfirst = 0;
        integ = 0;
        prev_err = 0;
        prev_drive = 0;
        prev_target = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset gains, then a fixed setting with every path
        push_tick(32'sh7fffffff, 32'sh80000000);
        wait_drained();
        write_reg(REG_GAIN_P, {32'h0, 32'h00010000});
        write_reg(REG_GAIN_I, {32'h0, 32'h00008000});
        write_reg(REG_GAIN_D, {32'h0, 32'h00004000});
        write_reg(REG_GAIN_F, {32'h0, 32'h00020000});
        write_reg(REG_LIMITS, {32'h00500000, 32'h00100000});
        write_reg(REG_BANDS, {32'h00080000, 32'h00010000});
        write_reg(REG_SPEED, {32'h00040000, 32'h00020000});
        write_reg(REG_DFIRST, 64'h0);
        push_tick(32'sh00008000, 32'sh0);
        push_tick(32'sh00010000, 32'sh0);
        push_tick(32'sh00018000, 32'sh0);
        push_tick(32'sh00030000, 32'sh0);
        push_tick(-32'sh00030000, 32'sh0);
        push_tick(32'sh00040000, 32'sh0);
        push_tick(32'sh00050000, 32'sh0);
        push_tick(32'sh00090000, 32'sh0);
        push_tick(32'sh00100000, 32'sh0);
        push_tick(32'sh7fffffff, 32'sh80000000);
        push_tick(32'sh80000000, 32'sh7fffffff);
        push_tick(32'sh0, 32'sh0);
        wait_drained();
        write_reg(REG_DFIRST, 64'h1);
        push_tick(32'sh00030000, 32'sh0);
        push_tick(32'sh7fffffff, 32'sh0);
        push_tick(32'sh80000000, 32'sh0);
        push_tick(32'sh0, 32'sh80000000);
        wait_drained();
        random_setting(1'b1);
        push_tick(32'sh7fffffff, 32'sh80000000);
        push_tick(32'sh80000000, 32'sh7fffffff);
        push_tick(32'sh12345678, 32'sh12345678);
        wait_drained();

        rand_idle = 1'b1;
        for (int phase = 0; phase < 14; phase++)
        begin
            int scale;
            random_setting(phase == 13);
            scale = 1 << $urandom_range(12, 22);
            for (int k = 0; k < 125; k++)
            begin
                logic signed [31:0] base;
                base = rand_value(1 << 24);
                push_tick(sat(66'(base) + 66'(rand_value(scale))), base);
            end
            if (phase == 4)
            begin
                // long hold-off on the receiving side while items keep coming
                hold_off = 1'b1;
                while (hold_cycles < 300)
                begin
                    @(posedge clk);
                end
                hold_off = 1'b0;
            end
            if (phase == 12)
            begin
                rand_idle = 1'b0;
            end
            wait_drained();
        end

        wait_drained();
        if (failures == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
